FILE: sv/sst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg: shared types and codes of the star separation thinning block
// Beat and store entry layouts, class codes, register indexes, FSM states.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int CompW = 16;
  localparam int PsumW = 34;
  localparam int NumComp = 3;

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic signed [PsumW-1:0] psum_t;

  typedef struct packed {
    logic pat;
    comp_t [NumComp-1:0] comp;
  } entry_t;

  // one stored star travelling down the cell chain
  typedef struct packed {
    logic valid;
    logic pat;
    comp_t [NumComp-1:0] comp;
    psum_t psum;
  } beat_t;

  typedef struct packed {
    logic pat_sep;
    logic all_sep;
    logic [7:0] pat_in;
    logic [7:0] all_in;
  } tally_t;

  typedef enum logic [1:0] {
    CLS_REJECT = 2'd0,
    CLS_VERIFY = 2'd1,
    CLS_PATTERN = 2'd2
  } class_t;

  localparam logic [7:0] REG_MIN_SEP = 8'd0;
  localparam logic [7:0] REG_HALF_FOV = 8'd1;
  localparam logic [7:0] REG_PAT_LIMIT = 8'd2;
  localparam logic [7:0] REG_VER_LIMIT = 8'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

FILE: sv/sst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_cell: one component cell of the dot product chain
// Adds the product of its own component and the leading stored component to
// the running sum, then shifts the stored components down for the next cell.
// ----------------------------------------------------------------------------
module sst_cell (
  input  logic            clk,
  input  logic            rst,
  input  sst_pkg::comp_t  own,
  input  sst_pkg::beat_t  beat_in,
  output sst_pkg::beat_t  beat_out
);

  sst_pkg::beat_t beat_next;
  logic signed [2*sst_pkg::CompW-1:0] prod;

  always_comb begin
    prod = own * beat_in.comp[0];
    beat_next = beat_in;
    beat_next.psum = beat_in.psum + sst_pkg::PsumW'(prod);
    for (int k = 0; k < sst_pkg::NumComp - 1; k++) begin
      beat_next.comp[k] = beat_in.comp[k+1];
    end
    beat_next.comp[sst_pkg::NumComp-1] = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_out.valid <= 1'b0;
    end else begin
      beat_out.valid <= beat_in.valid;
    end
    beat_out.pat <= beat_next.pat;
    beat_out.comp <= beat_next.comp;
    beat_out.psum <= beat_next.psum;
  end

endmodule

FILE: sv/sst_tally.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_tally: separation and field-of-view tally
// Compares each finished dot product with both thresholds and keeps the
// separation flags and saturating inside counts for the current star.
// ----------------------------------------------------------------------------
module sst_tally #(
  parameter int VEC_FRAC_BITS = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  sst_pkg::beat_t      beat,
  input  logic signed [29:0]  min_sep_cos,
  input  logic signed [29:0]  half_fov_cos,
  output sst_pkg::tally_t     tally
);

  localparam int DSH = (2 * VEC_FRAC_BITS < 28) ? 28 - 2 * VEC_FRAC_BITS : 0;
  localparam int TSH = (2 * VEC_FRAC_BITS > 28) ? 2 * VEC_FRAC_BITS - 28 : 0;
  localparam int CW = sst_pkg::PsumW + DSH + TSH + 2;

  logic signed [CW-1:0] dot_al, sep_al, fov_al;
  logic sep, in_fov;
  sst_pkg::tally_t tally_next;

  always_comb begin
    dot_al = CW'(beat.psum) <<< DSH;
    sep_al = CW'(min_sep_cos) <<< TSH;
    fov_al = CW'(half_fov_cos) <<< TSH;
    sep = dot_al < sep_al;
    in_fov = dot_al > fov_al;
    tally_next = tally;
    if (!sep) begin
      tally_next.all_sep = 1'b0;
    end
    if (in_fov && tally.all_in != 8'hFF) begin
      tally_next.all_in = tally.all_in + 8'd1;
    end
    if (beat.pat) begin
      if (!sep) begin
        tally_next.pat_sep = 1'b0;
      end
      if (in_fov && tally.pat_in != 8'hFF) begin
        tally_next.pat_in = tally.pat_in + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      tally <= '{pat_sep: 1'b1, all_sep: 1'b1, pat_in: 8'd0, all_in: 8'd0};
    end else if (beat.valid) begin
      tally <= tally_next;
    end
  end

endmodule

FILE: sv/star_separation_thinning.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// star_separation_thinning: greedy minimum separation star filter
// Scans the star store one entry a cycle through a chain of component cells
// and classes each new star as pattern, verification only or rejected.
// ----------------------------------------------------------------------------
// The scan reads one stored star per cycle through the store read port; an
//   empty or full store skips the scan and goes straight to the decision.
// Handshake: start is not taken while busy, so one star is handled at a time;
//   start is taken again in the same cycle as the done strobe.
// Reset clears the stored count and the registers to their defaults; store
//   contents need no clearing. The receiver cannot stall the result.
module star_separation_thinning #(
  parameter int MAX_STARS = 4096,
  parameter int VEC_FRAC_BITS = 14
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  logic [15:0]  vec_x,
  input  logic [15:0]  vec_y,
  input  logic [15:0]  vec_z,
  output logic         done,
  output logic [1:0]   kept_class,
  output logic [11:0]  verify_slot,
  output logic         store_full,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int AW = (MAX_STARS > 1) ? $clog2(MAX_STARS) : 1;
  localparam int CNTW = $clog2(MAX_STARS + 1);

  sst_pkg::state_t state, state_next;
  logic [CNTW-1:0] count;
  logic [CNTW-1:0] count_last;
  logic [AW-1:0] raddr;
  logic rd_valid;
  sst_pkg::entry_t rdata;
  sst_pkg::entry_t store [MAX_STARS];
  sst_pkg::comp_t [sst_pkg::NumComp-1:0] own;
  sst_pkg::beat_t chain [sst_pkg::NumComp+1];
  sst_pkg::tally_t tally;
  logic signed [29:0] min_sep_cos, half_fov_cos;
  logic [7:0] pattern_per_fov, verify_per_fov;
  logic accept, in_flight, is_full, is_empty;
  logic [1:0] cls;
  logic [31:0] slot_wide;

  assign cfg_ready = 1'b1;
  assign busy = (state != sst_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign is_full = (count == CNTW'(MAX_STARS));
  assign is_empty = (count == '0);
  assign count_last = count - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_sep_cos <= 30'sd268166000;
      half_fov_cos <= 30'sd264000000;
      pattern_per_fov <= 8'd10;
      verify_per_fov <= 8'd20;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sst_pkg::REG_MIN_SEP: min_sep_cos <= cfg_data[29:0];
        sst_pkg::REG_HALF_FOV: half_fov_cos <= cfg_data[29:0];
        sst_pkg::REG_PAT_LIMIT: pattern_per_fov <= cfg_data[7:0];
        sst_pkg::REG_VER_LIMIT: verify_per_fov <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      own[0] <= vec_x;
      own[1] <= vec_y;
      own[2] <= vec_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_flight = rd_valid || chain[1].valid || chain[2].valid || chain[3].valid;

  always_comb begin
    state_next = state;
    unique case (state)
      sst_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (is_full || is_empty) ? sst_pkg::ST_DONE : sst_pkg::ST_SCAN;
        end
      end
      sst_pkg::ST_SCAN: begin
        if (raddr == count_last[AW-1:0]) begin
          state_next = sst_pkg::ST_DRAIN;
        end
      end
      sst_pkg::ST_DRAIN: begin
        if (!in_flight) begin
          state_next = sst_pkg::ST_DONE;
        end
      end
      sst_pkg::ST_DONE: state_next = sst_pkg::ST_IDLE;
      default: state_next = sst_pkg::ST_IDLE;
    endcase
  end

  // advance the read address over the filled part of the store
  always_ff @(posedge clk) begin
    if (rst) begin
      raddr <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == sst_pkg::ST_SCAN);
      if (state == sst_pkg::ST_SCAN) begin
        raddr <= raddr + 1'b1;
      end else begin
        raddr <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rdata <= store[raddr];
    if (state == sst_pkg::ST_DONE && cls != sst_pkg::CLS_REJECT) begin
      store[count[AW-1:0]] <= '{pat: (cls == sst_pkg::CLS_PATTERN), comp: own};
    end
  end

  always_comb begin
    chain[0].valid = rd_valid;
    chain[0].pat = rdata.pat;
    chain[0].comp = rdata.comp;
    chain[0].psum = '0;
  end

  for (genvar g = 0; g < sst_pkg::NumComp; g++) begin : g_cell
    sst_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .own      (own[g]),
      .beat_in  (chain[g]),
      .beat_out (chain[g+1])
    );
  end

  sst_tally #(
    .VEC_FRAC_BITS (VEC_FRAC_BITS)
  ) u_tally (
    .clk          (clk),
    .rst          (rst),
    .clear        (accept),
    .beat         (chain[sst_pkg::NumComp]),
    .min_sep_cos  (min_sep_cos),
    .half_fov_cos (half_fov_cos),
    .tally        (tally)
  );

  always_comb begin
    priority if (is_full) begin
      cls = sst_pkg::CLS_REJECT;
    end else if (is_empty) begin
      cls = sst_pkg::CLS_PATTERN;
    end else if (tally.pat_sep && tally.pat_in < pattern_per_fov) begin
      cls = sst_pkg::CLS_PATTERN;
    end else if (tally.all_sep && tally.all_in < verify_per_fov) begin
      cls = sst_pkg::CLS_VERIFY;
    end else begin
      cls = sst_pkg::CLS_REJECT;
    end
  end

  assign slot_wide = 32'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= (state == sst_pkg::ST_DONE);
      if (state == sst_pkg::ST_DONE && cls != sst_pkg::CLS_REJECT) begin
        count <= count + 1'b1;
      end
    end
    if (state == sst_pkg::ST_DONE) begin
      kept_class <= cls;
      verify_slot <= (cls != sst_pkg::CLS_REJECT) ? slot_wide[11:0] : 12'd0;
      store_full <= is_full;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_after_decide: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == sst_pkg::ST_DONE))
    else $error("result strobe without a decision cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(MAX_STARS))
    else $error("stored count beyond store depth");

  a_full_rejects: assert property (@(posedge clk) disable iff (rst)
    (done && store_full) |-> (kept_class == sst_pkg::CLS_REJECT && verify_slot == 12'd0))
    else $error("full store result not a rejection");

  a_chain_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == sst_pkg::ST_IDLE) |-> !in_flight)
    else $error("stored star in flight while idle");
`endif

endmodule

FILE: sim/star_separation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// star_separation_checker: prediction and comparison for the star filter
// Watches the star, result and register channels, predicts each star's class,
// slot and full flag from its own copy of the store, and counts mismatches.
// ----------------------------------------------------------------------------
module star_separation_checker #(
  parameter int MaxStars = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] vec_x,
  input  logic [15:0] vec_y,
  input  logic [15:0] vec_z,
  input  logic        done,
  input  logic [1:0]  kept_class,
  input  logic [11:0] verify_slot,
  input  logic        store_full,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               pat;
  } star_t;

  typedef struct {
    sst_pkg::class_t cls;
    logic [11:0]     slot;
    logic            full;
  } verdict_t;

  star_t              kept_stars [MaxStars];
  int                 kept_count;
  logic signed [29:0] sep_cos;
  logic signed [29:0] fov_cos;
  logic [7:0]         pat_limit;
  logic [7:0]         ver_limit;
  verdict_t           verdict_q[$];

  // class one star against the kept stars and file it if kept
  function automatic verdict_t classify_star(logic signed [15:0] x, logic signed [15:0] y,
                                             logic signed [15:0] z);
    verdict_t v;
    longint   d;
    longint   sep;
    longint   fov;
    bit       pat_sep;
    bit       all_sep;
    int       pat_in;
    int       all_in;
    pat_sep = 1;
    all_sep = 1;
    pat_in = 0;
    all_in = 0;
    sep = longint'(sep_cos);
    fov = longint'(fov_cos);
    v.cls = sst_pkg::CLS_REJECT;
    v.slot = '0;
    v.full = 1'b0;
    if (kept_count >= MaxStars) begin
      v.full = 1'b1;
    end else if (kept_count == 0) begin
      v.cls = sst_pkg::CLS_PATTERN;
    end else begin
      for (int i = 0; i < kept_count; i++) begin
        d = longint'(x) * kept_stars[i].x + longint'(y) * kept_stars[i].y
            + longint'(z) * kept_stars[i].z;
        if (!(d < sep)) all_sep = 0;
        if (d > fov) all_in++;
        if (kept_stars[i].pat) begin
          if (!(d < sep)) pat_sep = 0;
          if (d > fov) pat_in++;
        end
      end
      if (pat_sep && pat_in < pat_limit) v.cls = sst_pkg::CLS_PATTERN;
      else if (all_sep && all_in < ver_limit) v.cls = sst_pkg::CLS_VERIFY;
    end
    if (v.cls != sst_pkg::CLS_REJECT) begin
      v.slot = 12'(kept_count);
      kept_stars[kept_count] = '{x, y, z, v.cls == sst_pkg::CLS_PATTERN};
      kept_count++;
    end
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t v;
    if (rst) begin
      kept_count <= 0;
      sep_cos <= 30'sd268166000;
      fov_cos <= 30'sd264000000;
      pat_limit <= 8'd10;
      ver_limit <= 8'd20;
      fail_count <= 0;
      verdict_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sst_pkg::REG_MIN_SEP: sep_cos <= cfg_data[29:0];
          sst_pkg::REG_HALF_FOV: fov_cos <= cfg_data[29:0];
          sst_pkg::REG_PAT_LIMIT: pat_limit <= cfg_data[7:0];
          sst_pkg::REG_VER_LIMIT: ver_limit <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (done) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result beat with none expected: class %0d slot %0d full %0d",
                   $time, kept_class, verify_slot, store_full);
          fail_count <= fail_count + 1;
        end else begin
          v = verdict_q.pop_front();
          if (kept_class !== v.cls || verify_slot !== v.slot || store_full !== v.full) begin
            $display("%0t: expected class %0d slot %0d full %0d, got class %0d slot %0d full %0d",
                     $time, v.cls, v.slot, v.full, kept_class, verify_slot, store_full);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        verdict_q.insert(verdict_q.size(), classify_star(vec_x, vec_y, vec_z));
      end
    end
  end

  assign pending = verdict_q.size();

endmodule

FILE: sim/tb_star_separation_thinning.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_star_separation_thinning: stimulus and verdict for the star filter
// Directed stars and register extremes, then random sky, neighbor and noise
// stars over several register settings until the store fills up.
// ----------------------------------------------------------------------------
module tb_star_separation_thinning;

  localparam int MaxStars = 64;
  localparam int StallLimit = 3000;
  localparam int Full = 16384;
  // register indexes past the end of the register list
  localparam logic [7:0] RegPastEnd = 8'd4;
  localparam logic [7:0] RegTop = 8'd255;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [15:0] vec_x = '0;
  logic [15:0] vec_y = '0;
  logic [15:0] vec_z = '0;
  logic        done;
  logic [1:0]  kept_class;
  logic [11:0] verify_slot;
  logic        store_full;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          sender_idle;
  int          stall_cycles;
  int          sent_x[$];
  int          sent_y[$];
  int          sent_z[$];

  always #5 clk = ~clk;

  star_separation_thinning #(.MAX_STARS(MaxStars)) dut (.*);

  star_separation_checker #(.MaxStars(MaxStars)) u_checker (.*);

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == StallLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_star(int x, int y, int z);
    if ($urandom_range(99) < sender_idle) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1;
    vec_x <= 16'(x);
    vec_y <= 16'(y);
    vec_z <= 16'(z);
    sent_x.insert(sent_x.size(), x);
    sent_y.insert(sent_y.size(), y);
    sent_z.insert(sent_z.size(), z);
    do @(posedge clk); while (busy);
  endtask

  // hold off until every expected result is back
  task automatic drain();
    start <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic sky_star();
    real zc;
    real phi;
    real r;
    int  k;
    int  pick;
    pick = $urandom_range(99);
    if (pick < 65 || sent_x.size() == 0) begin
      zc = real'($urandom_range(2 * Full)) - Full;
      phi = 6.283185307 * real'($urandom_range(65535)) / 65536.0;
      r = $sqrt(real'(Full) * Full - zc * zc);
      send_star($rtoi(r * $cos(phi)), $rtoi(r * $sin(phi)), $rtoi(zc));
    end else if (pick < 90) begin
      // crowd an earlier star
      k = $urandom_range(sent_x.size() - 1);
      send_star(sent_x[k] + $urandom_range(800) - 400, sent_y[k] + $urandom_range(800) - 400,
                sent_z[k] + $urandom_range(800) - 400);
    end else begin
      send_star($urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    sender_idle = 18;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // empty store takes a pattern star even with zero limits
    write_reg(sst_pkg::REG_PAT_LIMIT, 0);
    write_reg(sst_pkg::REG_VER_LIMIT, 0);
    send_star(Full, 0, 0);
    send_star(0, Full, 0);
    drain();
    write_reg(sst_pkg::REG_PAT_LIMIT, 255);
    write_reg(sst_pkg::REG_VER_LIMIT, 255);
    write_reg(RegPastEnd, 32'hFFFF_FFFF);
    write_reg(RegTop, 0);
    write_reg(sst_pkg::REG_MIN_SEP, 32'hF000_0000);
    send_star(0, 0, Full);
    drain();
    write_reg(sst_pkg::REG_MIN_SEP, 32'h1000_0000);
    write_reg(sst_pkg::REG_HALF_FOV, 32'h3000_0000);
    send_star(Full, 0, 0);
    send_star(-Full, 0, 0);
    send_star(0, -Full, 0);
    send_star(0, 0, -Full);
    send_star(0, 0, 0);
    send_star(16'h7FFF, 16'h8000, 16'h7FFF);
    send_star(16'h8000, 16'h7FFF, 16'h8000);
    drain();
    // negative fov cosine: nearly everything is inside
    write_reg(sst_pkg::REG_HALF_FOV, 32'hF000_0000);
    write_reg(sst_pkg::REG_PAT_LIMIT, 3);
    write_reg(sst_pkg::REG_VER_LIMIT, 11);
    send_star(11585, 11585, 0);
    send_star(-11585, 11585, 0);
    send_star(0, 11585, -11585);
    send_star(11585, 0, 11585);
    send_star(9459, 9459, 9459);
    drain();
    write_reg(sst_pkg::REG_MIN_SEP, 32'h0FFF_FFFF);
    write_reg(sst_pkg::REG_PAT_LIMIT, 1);
    send_star(-9459, -9459, 9459);
    send_star(-9459, 9459, -9459);
    drain();

    write_reg(sst_pkg::REG_MIN_SEP, 32'h0B33_3333);
    write_reg(sst_pkg::REG_HALF_FOV, 32'h0800_0000);
    write_reg(sst_pkg::REG_PAT_LIMIT, 2);
    write_reg(sst_pkg::REG_VER_LIMIT, 4);
    repeat (45) sky_star();
    drain();

    sender_idle = 54;
    write_reg(sst_pkg::REG_MIN_SEP, 32'h04CC_CCCC);
    write_reg(sst_pkg::REG_HALF_FOV, 32'h3CCC_CCCC);
    write_reg(sst_pkg::REG_PAT_LIMIT, 5);
    write_reg(sst_pkg::REG_VER_LIMIT, 9);
    repeat (40) sky_star();
    drain();

    // loosen everything and run the store full
    sender_idle = 0;
    write_reg(sst_pkg::REG_MIN_SEP, 32'h0FFF_FFF0);
    write_reg(sst_pkg::REG_HALF_FOV, 32'h0FD0_0000);
    write_reg(sst_pkg::REG_PAT_LIMIT, 200);
    write_reg(sst_pkg::REG_VER_LIMIT, 255);
    repeat (40) sky_star();
    drain();
    repeat (MaxStars + 10) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
